// ===== rtl/core/vas_pkg.sv =====
// ----------------------------------------------------------------------------
// vas_pkg: shared types, constants and helpers for the voice allocator
// Voice table entry, command item, configuration bundle, note folding and
// stack count.
// ----------------------------------------------------------------------------
package vas_pkg;

  localparam int VOICES     = 16;
  localparam int VW         = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W      = 5;
  localparam int ADDR_W     = 4;
  localparam int TOP_NOTE   = 89;
  localparam int OCTAVE     = 12;
  localparam int LOW_CAP    = 78;
  localparam int FOLD_STEPS = 6;

  localparam logic [7:0] FREE_NOTE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_ON     = 2'd0,
    REQ_OFF    = 2'd1,
    REQ_ALLOFF = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_FWD   = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    REG_STACK_EN = 2'd0,
    REG_TIERS    = 2'd1,
    REG_STEAL    = 2'd2,
    REG_LOWEST   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FWD,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PASS_FILL,
    PASS_STEAL,
    PASS_OFF,
    PASS_ALLOFF
  } pass_t;

  typedef struct packed {
    logic [7:0]  note;
    logic [3:0]  ch;
    logic [31:0] age;
  } voice_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] vidx;
    logic [6:0] note;
    logic [3:0] ch;
    logic [6:0] vel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       stack_enable;
    logic [2:0] velocity_tiers;
    logic       steal_oldest;
    logic [6:0] lowest_note;
  } cfg_t;

  // raise one octave, then fold by octaves into lowest..TOP_NOTE, lowest capped at LOW_CAP
  function automatic logic [6:0] fold_note(input logic [6:0] n, input logic [6:0] lowest);
    logic [7:0] lo;
    logic [7:0] t;
    lo = (lowest > 7'(LOW_CAP)) ? 8'(LOW_CAP) : {1'b0, lowest};
    t  = {1'b0, n} + 8'(OCTAVE);
    for (int i = 0; i < FOLD_STEPS; i++) begin
      if (t > 8'(TOP_NOTE)) begin
        t = t - 8'(OCTAVE);
      end else if (t < lo) begin
        t = t + 8'(OCTAVE);
      end
    end
    return t[6:0];
  endfunction

  function automatic logic [CNT_W-1:0] stack_count(input logic en, input logic [2:0] tiers,
                                                   input logic [6:0] n, input logic [6:0] vel);
    logic [2:0] c;
    logic [2:0] f;
    logic [5:0] p;
    case (tiers)
      3'd4:    c = (vel < 7'd60) ? 3'd1 : (vel < 7'd80) ? 3'd2 : (vel < 7'd105) ? 3'd3 : 3'd4;
      3'd3:    c = (vel < 7'd80) ? 3'd1 : (vel < 7'd100) ? 3'd2 : 3'd3;
      3'd2:    c = (vel < 7'd90) ? 3'd1 : 3'd2;
      default: c = 3'd1;
    endcase
    f = (n > 7'd73) ? 3'd4 : (n > 7'd64) ? 3'd3 : (n > 7'd48) ? 3'd2 : 3'd1;
    p = {3'b0, c} * {3'b0, f};
    if (!en) begin
      p = 6'd1;
    end
    return p[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/vas_req_if.sv =====
// ----------------------------------------------------------------------------
// vas_req_if: MIDI event channel
// Valid/ready handshake carrying one event item.
// ----------------------------------------------------------------------------
interface vas_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] channel;
  logic [6:0] note;
  logic [6:0] velocity;

  modport source (output valid, req_type, channel, note, velocity, input ready);
  modport sink   (input valid, req_type, channel, note, velocity, output ready);
endinterface

// ===== rtl/core/vas_cmd_if.sv =====
// ----------------------------------------------------------------------------
// vas_cmd_if: voice command channel
// Valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface vas_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd_kind;
  logic [3:0] voice_index;
  logic [6:0] out_note;
  logic [3:0] out_channel;
  logic [6:0] out_velocity;
  logic       last;

  modport source (output valid, cmd_kind, voice_index, out_note, out_channel, out_velocity,
                  last, input ready);
  modport sink   (input valid, cmd_kind, voice_index, out_note, out_channel, out_velocity,
                  last, output ready);
endinterface

// ===== rtl/core/voice_allocator_with_stealing_top.sv =====
// ----------------------------------------------------------------------------
// voice_allocator_with_stealing_top: polyphonic voice allocator
// Each accepted event rotates the whole voice ring past the head, one cell per
// cycle unless the output stalls; each stolen voice adds another full pass and
// each forwarded note-on adds one command item. A new event is accepted only in
// idle, once the last command item of the previous event has reached the output
// register; an ignored request is accepted and dropped.
// Reset: all voices free, ages and start counter zero, registers at defaults;
// no clearing pass.
// ----------------------------------------------------------------------------
module voice_allocator_with_stealing_top (
  input  logic                       clk,
  input  logic                       rst,
  vas_req_if.sink                    req,
  vas_cmd_if.source                  cmd,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vas_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import vas_pkg::*;

  cfg_t   cfg;
  voice_t ring [VOICES];
  voice_t wb;
  logic   shift;

  vas_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar k = 0; k < VOICES; k++) begin : g_ring
    if (k == VOICES - 1) begin : g_tail
      vas_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .din(wb), .q(ring[k]));
    end else begin : g_mid
      vas_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .din(ring[k+1]), .q(ring[k]));
    end
  end

  vas_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .req   (req),
    .cmd   (cmd),
    .head  (ring[0]),
    .wb    (wb),
    .shift (shift)
  );

endmodule

// ===== rtl/core/vas_cell.sv =====
// ----------------------------------------------------------------------------
// vas_cell: one voice slot of the rotating voice ring
// Holds note, channel and age stamp; loads its neighbor's entry (the tail: the rewritten head entry) on shift.
// ----------------------------------------------------------------------------
module vas_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  vas_pkg::voice_t din,
  output vas_pkg::voice_t q
);
  import vas_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '{note: FREE_NOTE, ch: 4'd0, age: 32'd0};
    end else if (shift) begin
      q <= din;
    end
  end

endmodule

// ===== rtl/core/vas_cfg.sv =====
// ----------------------------------------------------------------------------
// vas_cfg: configuration registers
// APB-style register file; writes complete in the access cycle.
// ----------------------------------------------------------------------------
module vas_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vas_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output vas_pkg::cfg_t             cfg
);
  import vas_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{stack_enable: 1'b1, velocity_tiers: 3'd1, steal_oldest: 1'b1,
               lowest_note: 7'd30};
    end else if (wr) begin
      unique case (idx)
        REG_STACK_EN: cfg.stack_enable   <= pwdata[0];
        REG_TIERS:    cfg.velocity_tiers <= pwdata[2:0];
        REG_STEAL:    cfg.steal_oldest   <= pwdata[0];
        REG_LOWEST:   cfg.lowest_note    <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STACK_EN: prdata = {31'd0, cfg.stack_enable};
      REG_TIERS:    prdata = {29'd0, cfg.velocity_tiers};
      REG_STEAL:    prdata = {31'd0, cfg.steal_oldest};
      REG_LOWEST:   prdata = {25'd0, cfg.lowest_note};
    endcase
  end

endmodule

// ===== rtl/core/vas_ctrl.sv =====
// ----------------------------------------------------------------------------
// vas_ctrl: event sequencer at the head of the voice ring
// Rewrites the entry passing the ring head, tracks the oldest voice, and
// queues command items through a pending stage and an output register.
// ----------------------------------------------------------------------------
module vas_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  vas_pkg::cfg_t   cfg,
  vas_req_if.sink         req,
  vas_cmd_if.source       cmd,
  input  vas_pkg::voice_t head,
  output vas_pkg::voice_t wb,
  output logic            shift
);
  import vas_pkg::*;

  state_t           state, state_next;
  pass_t            pass, pass_next;
  logic [VW-1:0]    pos, pos_next;
  logic [VW-1:0]    target, target_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [31:0]      counter, counter_next;
  logic [31:0]      best_age, best_age_next;
  logic [VW-1:0]    best_idx, best_idx_next;
  logic [3:0]       ev_ch, ev_ch_next;
  logic [6:0]       ev_note, ev_note_next;
  logic [6:0]       ev_vel, ev_vel_next;
  logic [6:0]       ev_fold, ev_fold_next;
  cmd_t             pend, pend_next;
  logic             pend_v, pend_v_next;
  cmd_t             outr, outr_next;
  logic             out_v, out_v_next;
  logic             gen;
  cmd_t             gen_cmd;
  logic             out_free;
  logic             adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pass    <= PASS_FILL;
      pos     <= '0;
      cnt     <= '0;
      counter <= 32'd0;
      pend_v  <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      state   <= state_next;
      pass    <= pass_next;
      pos     <= pos_next;
      cnt     <= cnt_next;
      counter <= counter_next;
      pend_v  <= pend_v_next;
      out_v   <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    target   <= target_next;
    best_age <= best_age_next;
    best_idx <= best_idx_next;
    ev_ch    <= ev_ch_next;
    ev_note  <= ev_note_next;
    ev_vel   <= ev_vel_next;
    ev_fold  <= ev_fold_next;
    pend     <= pend_next;
    outr     <= outr_next;
  end

  always_comb begin
    state_next    = state;
    pass_next     = pass;
    pos_next      = pos;
    target_next   = target;
    cnt_next      = cnt;
    counter_next  = counter;
    best_age_next = best_age;
    best_idx_next = best_idx;
    ev_ch_next    = ev_ch;
    ev_note_next  = ev_note;
    ev_vel_next   = ev_vel;
    ev_fold_next  = ev_fold;
    pend_next     = pend;
    pend_v_next   = pend_v;
    outr_next     = outr;
    wb            = head;
    shift         = 1'b0;
    gen           = 1'b0;
    gen_cmd       = '0;
    req.ready     = (state == ST_IDLE);
    out_free      = !out_v || cmd.ready;
    adv           = !pend_v || out_free;
    out_v_next    = out_v && !cmd.ready;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          ev_ch_next   = req.channel;
          ev_note_next = req.note;
          ev_vel_next  = req.velocity;
          ev_fold_next = fold_note(req.note, cfg.lowest_note);
          pos_next     = '0;
          cnt_next     = stack_count(cfg.stack_enable, cfg.velocity_tiers, req.note,
                                     req.velocity);
          unique case (req_kind_t'(req.req_type))
            REQ_ON: begin
              state_next = ST_SCAN;
              pass_next  = PASS_FILL;
            end
            REQ_OFF: begin
              state_next = ST_SCAN;
              pass_next  = PASS_OFF;
            end
            REQ_ALLOFF: begin
              state_next = ST_SCAN;
              pass_next  = PASS_ALLOFF;
            end
            REQ_NONE: state_next = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        if (adv) begin
          shift = 1'b1;
          unique case (pass)
            PASS_FILL: begin
              if (head.note == FREE_NOTE && cnt != '0) begin
                wb           = '{note: {1'b0, ev_fold}, ch: ev_ch, age: counter};
                gen          = 1'b1;
                gen_cmd.kind = CMD_START;
                gen_cmd.note = ev_fold;
                cnt_next     = cnt - 1'b1;
                counter_next = counter + 32'd1;
              end
            end
            PASS_STEAL: begin
              if (pos == target) begin
                wb           = '{note: {1'b0, ev_fold}, ch: ev_ch, age: counter};
                gen          = 1'b1;
                gen_cmd.kind = CMD_START;
                gen_cmd.note = ev_fold;
                cnt_next     = cnt - 1'b1;
                counter_next = counter + 32'd1;
              end
            end
            PASS_OFF: begin
              if (head.note == {1'b0, ev_fold} && head.ch == ev_ch) begin
                wb           = '{note: FREE_NOTE, ch: 4'd0, age: head.age};
                gen          = 1'b1;
                gen_cmd.kind = CMD_STOP;
                gen_cmd.note = ev_fold;
              end
            end
            PASS_ALLOFF: begin
              if (head.note != FREE_NOTE && head.ch == ev_ch) begin
                wb           = '{note: FREE_NOTE, ch: 4'd0, age: head.age};
                gen          = 1'b1;
                gen_cmd.kind = CMD_STOP;
                gen_cmd.note = head.note[6:0];
              end
            end
          endcase
          gen_cmd.vidx = 4'(pos);

          // oldest voice over the updated entries, lowest index on ties
          if (pos == '0 || wb.age < best_age) begin
            best_age_next = wb.age;
            best_idx_next = pos;
          end

          if (pos == VW'(VOICES - 1)) begin
            pos_next = '0;
            if ((pass == PASS_FILL || pass == PASS_STEAL) && cnt_next != '0) begin
              if (cfg.steal_oldest) begin
                pass_next   = PASS_STEAL;
                target_next = best_idx_next;
              end else begin
                state_next = ST_FWD;
              end
            end else begin
              state_next = ST_FLUSH;
            end
          end else begin
            pos_next = pos + 1'b1;
          end
        end
      end

      ST_FWD: begin
        if (adv) begin
          gen          = 1'b1;
          gen_cmd.kind = CMD_FWD;
          gen_cmd.note = ev_note;
          gen_cmd.ch   = ev_ch;
          gen_cmd.vel  = ev_vel;
          cnt_next     = cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state_next = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          outr_next      = pend;
          outr_next.last = 1'b1;
          out_v_next     = 1'b1;
          pend_v_next    = 1'b0;
          state_next     = ST_IDLE;
        end
      end
    endcase

    // a new item pushes the pending one out; last is known only at the end
    if (gen) begin
      if (pend_v) begin
        outr_next  = pend;
        out_v_next = 1'b1;
      end
      pend_next   = gen_cmd;
      pend_v_next = 1'b1;
    end
  end

  assign cmd.valid        = out_v;
  assign cmd.cmd_kind     = outr.kind;
  assign cmd.voice_index  = outr.vidx;
  assign cmd.out_note     = outr.note;
  assign cmd.out_channel  = outr.ch;
  assign cmd.out_velocity = outr.vel;
  assign cmd.last         = outr.last;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v)
    else $error("pending item left while idle");

  a_steal_has_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && pass == PASS_STEAL && pos == target) || state == ST_FWD
      |-> cnt != '0)
    else $error("steal or forward with zero count");

  a_gen_has_room: assert property (@(posedge clk) disable iff (rst)
    gen |-> (!pend_v || out_free))
    else $error("item generated without room");

  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCAN |-> pos == '0)
    else $error("ring not aligned outside a scan");

endmodule
